// ===== rtl/core/bb3_pkg.sv =====
`timescale 1ns / 1ps

package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W   = 11;                  // frame size registers
    localparam int COL_W   = $clog2(MAX_WIDTH);   // column inside a row
    localparam int ADDR_W  = COL_W + 2;           // four rows in the line store
    localparam int MEM_DEPTH = 4 * (1 << COL_W);
    localparam int PIX_W   = 24;
    localparam int SUM_W   = 12;                  // 9 * 255
    localparam int CNT_W   = 4;                   // up to 9 neighbors
    localparam int NUM_W   = 13;                  // 2 * sum + count
    localparam int DEN_W   = 5;                   // 2 * count
    localparam int QUO_W   = 8;
    localparam int TAP_W   = 4;
    localparam int BIT_W   = 3;
    localparam int LAST_TAP = 8;

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } bb3_reg_t;

    typedef struct packed {
        logic       action;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } bb3_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } bb3_out_t;

    typedef struct packed {
        logic             accept;
        logic             eval;
        logic             tap_rd;
        logic [TAP_W-1:0] tap;
        logic             div_init;
        logic             div_step;
        logic [BIT_W-1:0] div_bit;
        logic             out_load;
    } bb3_cmd_t;

    typedef struct packed {
        logic need_blur;
        logic out_free;
    } bb3_status_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        if (v == '0) return DIM_W'(1);
        if (v > lim) return lim;
        return v;
    endfunction

    // window row (0 = above, 1 = center, 2 = below) of tap k
    function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/box_blur_three_by_three_top.sv =====
`timescale 1ns / 1ps
// channel | ports                         | payload
// input   | s_valid, s_ready, s_data      | bb3_in_t  (action, red/green/blue_in)
// result  | m_valid, m_ready, m_data      | bb3_out_t (red/green/blue_out, frame_end)
// config  | psel, penable, pwrite, paddr, | frame_width @0x0, frame_height @0x4
//         | pwdata, prdata, pready        |
//
// An item that yields a result goes through 9 line-store reads on the
// single read port, 8 divider steps and the output state; any other item does not.
// Results trail inputs by frame_width + 1 items; drain items flush the tail.
// Synchronous active-low reset clears control and frame counters, not the line store.
// A waiting result does not block the next item until its own result is ready.

module box_blur_three_by_three_top import bb3_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bb3_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output bb3_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic             wr;
    bb3_cmd_t         cmd;
    bb3_status_t      status;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end else if (wr) begin
            if (paddr[2] == REG_FRAME_WIDTH) width_reg <= pwdata[DIM_W-1:0];
            else height_reg <= pwdata[DIM_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_WIDTH) ? 32'(width_reg) : 32'(height_reg);

    bb3_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bb3_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .cmd        (cmd),
        .status     (status),
        .m_data     (m_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready)
    );

endmodule

// ===== rtl/core/bb3_ctrl.sv =====
`timescale 1ns / 1ps

module bb3_ctrl import bb3_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bb3_status_t status,
    output bb3_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TAP,
        ST_ACC,
        ST_DINIT,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t           state_reg;
    logic [TAP_W-1:0] tap_reg;
    logic [BIT_W-1:0] bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
            bit_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    tap_reg   <= '0;
                    state_reg <= status.need_blur ? ST_TAP : ST_IDLE;
                end
                ST_TAP: begin
                    tap_reg <= tap_reg + TAP_W'(1);
                    if (tap_reg == TAP_W'(LAST_TAP)) state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    state_reg <= ST_DINIT;
                end
                ST_DINIT: begin
                    bit_reg   <= '1;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    bit_reg <= bit_reg - BIT_W'(1);
                    if (bit_reg == '0) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (status.out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.accept   = s_valid && (state_reg == ST_IDLE);
        cmd.eval     = (state_reg == ST_EVAL);
        cmd.tap_rd   = (state_reg == ST_TAP);
        cmd.tap      = tap_reg;
        cmd.div_init = (state_reg == ST_DINIT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.div_bit  = bit_reg;
        cmd.out_load = (state_reg == ST_OUT) && status.out_free;
    end

endmodule

// ===== rtl/core/bb3_datapath.sv =====
`timescale 1ns / 1ps

module bb3_datapath import bb3_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  bb3_in_t          s_data,
    input  logic [DIM_W-1:0] cfg_width,
    input  logic [DIM_W-1:0] cfg_height,
    input  bb3_cmd_t         cmd,
    output bb3_status_t      status,
    output bb3_out_t         m_data,
    output logic             m_valid,
    input  logic             m_ready
);

    logic [PIX_W-1:0] mem [MEM_DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    bb3_in_t          item_reg;
    logic [DIM_W-1:0] cur_w_reg, cur_h_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [DIM_W-1:0] in_row_reg;
    logic [DIM_W-1:0] prime_reg;     // items taken this frame, saturating at width + 1
    logic [COL_W-1:0] out_col_reg;
    logic [DIM_W-1:0] out_row_reg;
    logic             acc_pend_reg;
    logic [SUM_W-1:0] sum_reg [3];
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] rem_reg [3];
    logic [QUO_W-1:0] quo_reg [3];
    logic [DEN_W-1:0] den_reg;
    bb3_out_t         out_reg;
    logic             m_valid_reg;

    logic [DIM_W-1:0]  w_eff, h_eff, col_next;
    logic              pix_phase, ignore, wr_en, last;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [1:0]        dy, dx;
    logic              row_ok, col_ok;
    logic [NUM_W-1:0]  den_sh;

    // frame size is latched by the first item of a frame
    assign w_eff = (prime_reg == '0) ? clamp_dim(cfg_width, MAX_W_DIM) : cur_w_reg;
    assign h_eff = (prime_reg == '0) ? clamp_dim(cfg_height, MAX_H_DIM) : cur_h_reg;
    assign pix_phase = (in_row_reg < h_eff);
    assign ignore    = pix_phase && item_reg.action;
    assign wr_en     = cmd.eval && pix_phase && !item_reg.action;
    assign col_next  = DIM_W'(in_col_reg) + DIM_W'(1);
    assign waddr     = {in_row_reg[1:0], in_col_reg};
    assign last      = (out_row_reg == cur_h_reg - DIM_W'(1))
                    && (DIM_W'(out_col_reg) == cur_w_reg - DIM_W'(1));

    assign status.need_blur = !ignore && (prime_reg > w_eff);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign dy = tap_row(cmd.tap);
    assign dx = tap_col(cmd.tap);

    always_comb begin
        case (dy)
            2'd0:    row_ok = (out_row_reg != '0);
            2'd2:    row_ok = (out_row_reg + DIM_W'(1)) < cur_h_reg;
            default: row_ok = 1'b1;
        endcase
        case (dx)
            2'd0:    col_ok = (out_col_reg != '0);
            2'd2:    col_ok = (DIM_W'(out_col_reg) + DIM_W'(1)) < cur_w_reg;
            default: col_ok = 1'b1;
        endcase
    end

    // rows wrap modulo four; out-of-frame taps are never accumulated
    assign raddr = {out_row_reg[1:0] + dy - 2'd1,
                    out_col_reg + COL_W'(dx) - COL_W'(1)};

    assign den_sh = NUM_W'(den_reg) << cmd.div_bit;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[waddr] <= {item_reg.red_in, item_reg.green_in, item_reg.blue_in};
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) item_reg <= s_data;
        if (cmd.eval) begin
            for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
            cnt_reg <= '0;
        end else if (acc_pend_reg) begin
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= sum_reg[i] + SUM_W'(rdata_reg[PIX_W-1-8*i -: 8]);
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.div_init) begin
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= {sum_reg[i], 1'b0} + NUM_W'(cnt_reg);
                quo_reg[i] <= '0;
            end
            den_reg <= {cnt_reg, 1'b0};
        end else if (cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                if (rem_reg[i] >= den_sh) begin
                    rem_reg[i]              <= rem_reg[i] - den_sh;
                    quo_reg[i][cmd.div_bit] <= 1'b1;
                end
            end
        end
        if (cmd.out_load) begin
            out_reg.red_out   <= quo_reg[0];
            out_reg.green_out <= quo_reg[1];
            out_reg.blue_out  <= quo_reg[2];
            out_reg.frame_end <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_w_reg    <= '0;
            cur_h_reg    <= '0;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            prime_reg    <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            acc_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            acc_pend_reg <= cmd.tap_rd && row_ok && col_ok;
            if (cmd.eval) begin
                cur_w_reg <= w_eff;
                cur_h_reg <= h_eff;
                if (!ignore) begin
                    if (pix_phase) begin
                        if (col_next >= w_eff) begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + DIM_W'(1);
                        end else begin
                            in_col_reg <= col_next[COL_W-1:0];
                        end
                    end
                    if (prime_reg <= w_eff) prime_reg <= prime_reg + DIM_W'(1);
                end
            end
            if (cmd.out_load) begin
                if (last) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    prime_reg   <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else if (DIM_W'(out_col_reg) + DIM_W'(1) >= cur_w_reg) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + DIM_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    // the center pixel is always inside the frame
    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_init |-> (cnt_reg != '0))
        else $error("blur window has no pixel");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwrites an untaken item");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (rem_reg[0] < NUM_W'(den_reg)) && (rem_reg[1] < NUM_W'(den_reg))
                      && (rem_reg[2] < NUM_W'(den_reg)))
        else $error("quotient overflow in divider");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bb3_pkg::*;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;
    localparam int   SETTLE    = 40;
    localparam int   LIMIT     = 3000000;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PRED,
        ROW_TYPED
    } row_kind_t;

    typedef struct {
        row_kind_t      kind;
        bb3_reg_t       reg_sel;
        logic [10:0]    reg_val;
        bb3_in_t        pix;
        bb3_out_t       want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    bb3_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    bb3_out_t    m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_blur_three_by_three_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // blur predictor state
    logic [10:0] reg_w, reg_h;
    int          cur_w, cur_h, taken, in_col, in_row, out_pos;
    logic [23:0] line_mem [4096];

    bb3_out_t    blur_queue [$];
    int          errors = 0;
    int          cycles = 0;
    bit          no_idle = 0;
    int          stall_left = 0;
    int          n_items = 0;

    function automatic int eff_dim(input logic [10:0] v, input int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return int'(v);
    endfunction

    function automatic bit blur_step(input bb3_in_t d, output bb3_out_t o);
        int p, q, r, c, rr, cc, cnt, sr, sg, sb;
        logic [23:0] px;
        o = '0;
        if (taken == 0) begin
            cur_w = eff_dim(reg_w, MAX_WIDTH);
            cur_h = eff_dim(reg_h, MAX_HEIGHT);
        end
        if (in_row < cur_h) begin
            if (d.action == ACT_DRAIN) return 0;
            line_mem[(in_row % 4) * 1024 + in_col] = {d.red_in, d.green_in, d.blue_in};
            in_col++;
            if (in_col >= cur_w) begin
                in_col = 0;
                in_row++;
            end
        end
        p = taken;
        taken++;
        if (p <= cur_w) return 0;
        q = out_pos;
        out_pos++;
        r = q / cur_w;
        c = q % cur_w;
        cnt = 0; sr = 0; sg = 0; sb = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                rr = r + dy;
                cc = c + dx;
                if (rr >= 0 && rr < cur_h && cc >= 0 && cc < cur_w) begin
                    px = line_mem[(rr % 4) * 1024 + cc];
                    sr += px[23:16];
                    sg += px[15:8];
                    sb += px[7:0];
                    cnt++;
                end
            end
        end
        // round half up
        o.red_out   = 8'((2 * sr + cnt) / (2 * cnt));
        o.green_out = 8'((2 * sg + cnt) / (2 * cnt));
        o.blue_out  = 8'((2 * sb + cnt) / (2 * cnt));
        o.frame_end = (q + 1 >= cur_w * cur_h);
        if (o.frame_end) begin
            in_col = 0;
            in_row = 0;
            out_pos = 0;
            taken = 0;
        end
        return 1;
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check, then decide stall for next cycle
    always @(posedge aclk) begin
        bb3_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (blur_queue.size() == 0) begin
                report("unexpected item", 8'd0, 8'd0);
            end else begin
                want = blur_queue.pop_front();
                if (m_data.red_out !== want.red_out)
                    report("red_out", m_data.red_out, want.red_out);
                if (m_data.green_out !== want.green_out)
                    report("green_out", m_data.green_out, want.green_out);
                if (m_data.blue_out !== want.blue_out)
                    report("blue_out", m_data.blue_out, want.blue_out);
                if (m_data.frame_end !== want.frame_end)
                    report("frame_end", 8'(m_data.frame_end), 8'(want.frame_end));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic wait_idle();
        while (blur_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input bb3_reg_t sel, input logic [10:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {sel, 2'b00};
        pwdata <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_FRAME_WIDTH) reg_w = val;
        else reg_h = val;
        @(posedge aclk);
    endtask

    // returns the predictor result for the accepted item
    task automatic send(input bb3_in_t d, output bit got, output bb3_out_t o);
        int gap;
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        do @(posedge aclk); while (!s_ready);
        got = blur_step(d, o);
        n_items++;
    endtask

    task automatic send_pred(input bb3_in_t d);
        bit got;
        bb3_out_t o;
        send(d, got, o);
        if (got) blur_queue.push_back(o);
    endtask

    function automatic bb3_in_t rand_item(input logic act);
        bb3_in_t d;
        d = bb3_in_t'(25'($urandom));
        d.action = act;
        return d;
    endfunction

    // one well-formed frame with random content and some noise
    task automatic run_frame();
        int fw, fh;
        fw = eff_dim(reg_w, MAX_WIDTH);
        fh = eff_dim(reg_h, MAX_HEIGHT);
        for (int i = 0; i < fw * fh; i++) begin
            // drains while pixels are missing are ignored
            if ($urandom_range(0, 9) == 0) send_pred(rand_item(ACT_DRAIN));
            send_pred(rand_item(ACT_PIXEL));
        end
        // tail: extra pixels act as drains
        for (int i = 0; i <= fw; i++)
            send_pred(rand_item($urandom_range(0, 3) == 0 ? ACT_PIXEL : ACT_DRAIN));
    endtask

    function automatic row_t mk(input row_kind_t k, input bb3_reg_t sel, input int val,
                                input logic [24:0] pix, input logic [24:0] want);
        row_t t;
        t.kind = k;
        t.reg_sel = sel;
        t.reg_val = 11'(val);
        t.pix = bb3_in_t'(pix);
        t.want = bb3_out_t'(want);
        return t;
    endfunction

    initial begin
        row_t     rows [$];
        bit       got;
        bb3_out_t o;
        int       ext_w [6];
        int       ext_h [6];
        int       rnd_start;

        for (int i = 0; i < 4096; i++) line_mem[i] = '0;
        reg_w = RESET_WIDTH;
        reg_h = RESET_HEIGHT;
        cur_w = 0; cur_h = 0; taken = 0; in_col = 0; in_row = 0; out_pos = 0;

        // 1x1 frames: result is the pixel itself
        rows.push_back(mk(ROW_CFG, REG_FRAME_WIDTH, 1, '0, '0));
        rows.push_back(mk(ROW_CFG, REG_FRAME_HEIGHT, 1, '0, '0));
        rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0, {ACT_DRAIN, 24'h000000}, '0));
        rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0, {ACT_PIXEL, 24'hff0080}, '0));
        rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0, {ACT_PIXEL, 24'h123456}, '0));
        rows.push_back(mk(ROW_TYPED, REG_FRAME_WIDTH, 0, {ACT_DRAIN, 24'hffffff},
                          {24'hff0080, 1'b1}));
        rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0, {ACT_PIXEL, 24'h00ff01}, '0));
        rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0, {ACT_DRAIN, 24'h000000}, '0));
        rows.push_back(mk(ROW_TYPED, REG_FRAME_WIDTH, 0, {ACT_DRAIN, 24'h000000},
                          {24'h00ff01, 1'b1}));
        // 2x1 frame: half-way sums round up
        rows.push_back(mk(ROW_CFG, REG_FRAME_WIDTH, 2, '0, '0));
        rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0, {ACT_PIXEL, 24'h0100ff}, '0));
        rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0, {ACT_PIXEL, 24'h000000}, '0));
        rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0, {ACT_DRAIN, 24'h000000}, '0));
        rows.push_back(mk(ROW_TYPED, REG_FRAME_WIDTH, 0, {ACT_DRAIN, 24'h000000},
                          {24'h010080, 1'b0}));
        rows.push_back(mk(ROW_TYPED, REG_FRAME_WIDTH, 0, {ACT_PIXEL, 24'hffffff},
                          {24'h010080, 1'b1}));
        // 3x3 frame of full-scale and zero pixels
        rows.push_back(mk(ROW_CFG, REG_FRAME_WIDTH, 3, '0, '0));
        rows.push_back(mk(ROW_CFG, REG_FRAME_HEIGHT, 3, '0, '0));
        for (int i = 0; i < 9; i++)
            rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0,
                              {ACT_PIXEL, (i % 2) ? 24'h000000 : 24'hffffff}, '0));
        for (int i = 0; i < 4; i++)
            rows.push_back(mk(ROW_PRED, REG_FRAME_WIDTH, 0, {ACT_DRAIN, 24'h0}, '0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                s_valid <= 1'b0;
                wait_idle();
                write_reg(rows[i].reg_sel, rows[i].reg_val);
            end else begin
                send(rows[i].pix, got, o);
                if (got) blur_queue.push_back(rows[i].kind == ROW_TYPED ? rows[i].want : o);
            end
        end

        // size extremes, out-of-range values clamp
        ext_w = '{0, 1, 1, 3, 5, 1};
        ext_h = '{3, 1, 0, 1, 2, 1};
        foreach (ext_w[i]) begin
            s_valid <= 1'b0;
            wait_idle();
            write_reg(REG_FRAME_WIDTH, 11'(ext_w[i]));
            write_reg(REG_FRAME_HEIGHT, 11'(ext_h[i]));
            run_frame();
        end

        rnd_start = n_items;
        while (n_items - rnd_start < 1185) begin
            if (n_items - rnd_start > 1000) no_idle = 1;
            if (!no_idle && $urandom_range(0, 2) == 0) begin
                s_valid <= 1'b0;
                wait_idle();
                write_reg(REG_FRAME_WIDTH, 11'($urandom_range(1, 8)));
                write_reg(REG_FRAME_HEIGHT, 11'($urandom_range(1, 6)));
            end
            run_frame();
        end

        s_valid <= 1'b0;
        wait_idle();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
